/* hw/rtl/qjtg_pkg.sv */
//------------------------------------------------------------------------------
// qjtg_pkg: shared types and constants of the quintic trajectory generator
// Request codes, widths, and the queue entry handed from front to back.
//------------------------------------------------------------------------------
`default_nettype none

package qjtg_pkg;

  localparam int NumJointsDef  = 7;
  localparam int AngleWidthDef = 32;
  localparam int OutJoints     = 7;
  localparam int DurW          = 26;
  localparam int PerW          = 17;
  localparam int TlW           = 27;
  localparam int IdxW          = 3;
  localparam int Q             = 30;

  localparam logic [DurW-1:0] DurReset = 26'd1000000;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_START = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  // One tick job, passed from the front to the back through the queue.
  typedef struct packed {
    logic [DurW-1:0] elapsed;
    logic [DurW-1:0] dur;
    logic            finished;
    logic            abort_req;
  } job_t;

endpackage : qjtg_pkg

`default_nettype wire

/* hw/rtl/qjtg_front.sv */
//------------------------------------------------------------------------------
// qjtg_front: request decoder and motion state
// Stores endpoints are in the back; this part keeps elapsed time and armed
// state, and queues one job per armed tick.
//------------------------------------------------------------------------------
`default_nettype none

module qjtg_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            in_req_type,
  input  wire logic [qjtg_pkg::PerW-1:0] in_period_us,
  input  wire logic                  in_abort,
  input  wire logic [qjtg_pkg::DurW-1:0] dur,
  input  wire logic                  busy,
  output logic                       job_valid,
  output qjtg_pkg::job_t             job,
  input  wire logic                  job_ready
);
  import qjtg_pkg::*;

  logic            armed_r, armed_nxt;
  logic [DurW-1:0] elapsed_r, elapsed_nxt;
  logic [DurW:0]   sum;
  logic [DurW-1:0] el_new;
  logic            acc, fin;
  req_t            req;

  assign req      = req_t'(in_req_type);
  // An armed tick needs queue room. A load waits until every earlier tick has read
  // the endpoints, so it only affects later ticks. A start never waits.
  assign in_ready = (req == REQ_TICK) ? (!armed_r || job_ready)
                                      : ((req != REQ_LOAD) || !busy);
  assign acc      = in_valid && in_ready;

  // Saturating add of the tick period.
  assign sum    = {1'b0, elapsed_r} + {{(DurW+1-PerW){1'b0}}, in_period_us};
  assign el_new = sum[DurW] ? {DurW{1'b1}} : sum[DurW-1:0];
  assign fin    = el_new >= dur;

  always_comb begin
    armed_nxt   = armed_r;
    elapsed_nxt = elapsed_r;
    job_valid   = 1'b0;
    if (acc) begin
      unique case (req)
        REQ_START: begin
          armed_nxt   = 1'b1;
          elapsed_nxt = '0;
        end
        REQ_TICK: begin
          if (armed_r) begin
            elapsed_nxt = el_new;
            job_valid   = 1'b1;
            if (fin || in_abort) armed_nxt = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign job.elapsed   = el_new;
  assign job.dur       = dur;
  assign job.finished  = fin;
  assign job.abort_req = in_abort;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r   <= 1'b0;
      elapsed_r <= '0;
    end else begin
      armed_r   <= armed_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

endmodule : qjtg_front

`default_nettype wire

/* hw/rtl/qjtg_back.sv */
//------------------------------------------------------------------------------
// qjtg_back: tau division, blend polynomial and per-joint scaling
// A restoring divider makes tau one bit a cycle, then a sequencer reuses one
// multiplier for the polynomial and for each joint offset.
//------------------------------------------------------------------------------
`default_nettype none

module qjtg_back #(
  parameter int NUM_JOINTS  = qjtg_pkg::NumJointsDef,
  parameter int ANGLE_WIDTH = qjtg_pkg::AngleWidthDef
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     job_valid,
  input  wire qjtg_pkg::job_t           job,
  output logic                          job_ready,
  input  wire logic                     out_ready,
  output logic                          out_valid,
  output logic [qjtg_pkg::OutJoints-1:0][ANGLE_WIDTH-1:0] cmd,
  output logic [qjtg_pkg::TlW-1:0]      tl,
  output logic                          done,
  output logic                          pre,
  // Endpoint writes come straight from the input port.
  input  wire logic                     ld_en,
  input  wire logic [qjtg_pkg::IdxW-1:0] ld_idx,
  input  wire logic [ANGLE_WIDTH-1:0]   ld_start,
  input  wire logic [ANGLE_WIDTH-1:0]   ld_goal
);
  import qjtg_pkg::*;

  localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
  localparam int MW = ANGLE_WIDTH + 1;   // magnitude of a difference
  localparam int PW = MW + Q + 1;        // multiplier operand width

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_DIV = 7'b0000010, S_T2 = 7'b0000100,
    S_T3   = 7'b0001000, S_S  = 7'b0010000, S_JNT = 7'b0100000,
    S_OUT  = 7'b1000000
  } st_t;

  logic [ANGLE_WIDTH-1:0] st_mem [NUM_JOINTS];
  logic [ANGLE_WIDTH-1:0] gl_mem [NUM_JOINTS];

  st_t             st_r, st_nxt;
  job_t            job_r;
  logic [DurW:0]   rem_r;
  logic [Q:0]      tau_r;
  logic [5:0]      cnt_r;
  logic [Q:0]      t2_r, t3_r, s_r;
  logic [JW-1:0]   j_r;
  logic            ph_r;          // joint step: 0 read, 1 multiply
  logic            neg_r;
  logic [MW-1:0]   mag_r;
  logic [ANGLE_WIDTH-1:0] sta_r, rs_r, rg_r;
  logic [OutJoints-1:0][ANGLE_WIDTH-1:0] cmd_r;
  logic            ov_r;

  logic [DurW+1:0]  trial;
  logic [PW-1:0]    mul_a, mul_b;
  logic [2*PW-1:0]  prod;
  logic [Q+4:0]     inner;
  logic [Q+4:0]     poly;
  logic [Q+1:0]     sraw;
  logic signed [ANGLE_WIDTH:0] diff;
  logic [ANGLE_WIDTH-1:0] off;
  logic [JW-1:0]   rd_idx;

  // The multiply phase of a joint already fetches the next joint's endpoints.
  assign rd_idx = (st_r == S_JNT && ph_r && j_r != JW'(NUM_JOINTS - 1)) ?
                  j_r + JW'(1) : j_r;

  // Endpoint storage, written by loads, read one joint a cycle.
  always_ff @(posedge clk) begin
    if (ld_en && (ld_idx < IdxW'(NUM_JOINTS))) begin
      st_mem[ld_idx[JW-1:0]] <= ld_start;
      gl_mem[ld_idx[JW-1:0]] <= ld_goal;
    end
    rs_r <= st_mem[rd_idx];
    rg_r <= gl_mem[rd_idx];
  end

  assign job_ready = (st_r == S_IDLE);
  assign trial     = {rem_r, 1'b0} - {2'b0, job_r.dur};

  // Shared multiplier operands.
  assign inner = (Q+5)'(10) << Q;
  assign poly  = inner + {4'b0, t2_r} * (Q+5)'(6) - {4'b0, tau_r} * (Q+5)'(15);
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (st_r)
      S_T2:    begin mul_a = PW'(tau_r); mul_b = PW'(tau_r); end
      S_T3:    begin mul_a = PW'(t2_r);  mul_b = PW'(tau_r); end
      S_S:     begin mul_a = PW'(t3_r);  mul_b = PW'(poly);  end
      S_JNT:   begin mul_a = PW'(mag_r); mul_b = PW'(s_r); end
      default: ;
    endcase
  end
  assign prod = mul_a * mul_b;
  assign sraw = prod[Q+Q+1:Q];
  assign diff = $signed({rg_r[ANGLE_WIDTH-1], rg_r}) - $signed({rs_r[ANGLE_WIDTH-1], rs_r});
  assign off  = prod[Q+ANGLE_WIDTH-1:Q];

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (job_valid) st_nxt = S_DIV;
      S_DIV:  if (job_r.finished || cnt_r == 6'd1) st_nxt = S_T2;
      S_T2:   st_nxt = S_T3;
      S_T3:   st_nxt = S_S;
      S_S:    st_nxt = S_JNT;
      S_JNT:  if (ph_r && j_r == JW'(NUM_JOINTS - 1)) st_nxt = S_OUT;
      S_OUT:  if (ov_r && out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (ov_r && out_ready) ov_r <= 1'b0;
      else if (st_r == S_OUT && !ov_r) ov_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      S_IDLE: begin
        job_r <= job;
        rem_r <= {1'b0, job.elapsed};
        tau_r <= '0;
        cnt_r <= 6'(Q);
        j_r   <= '0;
        ph_r  <= 1'b0;
        cmd_r <= '0;
      end
      // One quotient bit per cycle: tau = elapsed * 2^30 / dur; a finished job sets tau to 2^30.
      S_DIV: begin
        if (job_r.finished) begin
          tau_r <= (Q+1)'(1) << Q;
        end else begin
          if (!trial[DurW+1]) begin
            rem_r <= trial[DurW:0];
            tau_r <= {tau_r[Q-1:0], 1'b1};
          end else begin
            rem_r <= {rem_r[DurW-1:0], 1'b0};
            tau_r <= {tau_r[Q-1:0], 1'b0};
          end
          cnt_r <= cnt_r - 6'd1;
        end
      end
      S_T2: t2_r <= sraw[Q:0];
      S_T3: t3_r <= sraw[Q:0];
      S_S:  s_r  <= (sraw > (Q+2)'(1) << Q) ? (Q+1)'(1) << Q : sraw[Q:0];
      S_JNT: begin
        if (!ph_r) begin
          neg_r <= diff < 0;
          mag_r <= (diff < 0) ? MW'(-diff) : MW'(diff);
          sta_r <= rs_r;
          ph_r  <= 1'b1;
        end else begin
          cmd_r[j_r] <= neg_r ? sta_r - off : sta_r + off;
          j_r  <= j_r + JW'(1);
          ph_r <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  // The result register parts the back end from the output channel.
  assign out_valid = ov_r;
  assign cmd  = cmd_r;
  assign tl   = TlW'({1'b0, job_r.dur}) - TlW'({1'b0, job_r.elapsed});
  assign done = job_r.finished || job_r.abort_req;
  assign pre  = job_r.abort_req;

endmodule : qjtg_back

`default_nettype wire

/* hw/rtl/qjtg_queue.sv */
//------------------------------------------------------------------------------
// qjtg_queue: two-entry job queue between front and back
// Lets the front keep accepting while the back works on a tick.
//------------------------------------------------------------------------------
`default_nettype none

module qjtg_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_valid,
  input  wire qjtg_pkg::job_t wr_data,
  output logic                wr_ready,
  output logic                rd_valid,
  output qjtg_pkg::job_t      rd_data,
  input  wire logic           rd_ready
);
  import qjtg_pkg::*;

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wp_r <= ~wp_r;
      if (rd_valid && rd_ready) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end

endmodule : qjtg_queue

`default_nettype wire

/* hw/rtl/quintic_joint_trajectory_gen_unit.sv */
//------------------------------------------------------------------------------
// quintic_joint_trajectory_gen_unit: minimum-jerk setpoint generator
// Loads endpoints, arms on start, and gives one command set per armed tick.
//------------------------------------------------------------------------------
// Start beats are never held. A load beat waits until the back end has
// finished every tick accepted before it. In the back end an armed tick beat
// goes through these steps in order: the job is taken, the bit-serial tau
// divider runs (a finished job skips it), three polynomial multiplies follow,
// each joint takes a read and a multiply step on the shared multiplier, and
// the result is handed over. Up to two ticks queue ahead of the back end.
`default_nettype none

module quintic_joint_trajectory_gen_unit #(
  parameter int NUM_JOINTS  = qjtg_pkg::NumJointsDef,
  parameter int ANGLE_WIDTH = qjtg_pkg::AngleWidthDef
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [qjtg_pkg::DurW-1:0] cfg_wdata,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [1:0]             in_req_type,
  input  wire logic [qjtg_pkg::IdxW-1:0] in_joint_index,
  input  wire logic signed [ANGLE_WIDTH-1:0] in_start_angle,
  input  wire logic signed [ANGLE_WIDTH-1:0] in_goal_angle,
  input  wire logic [qjtg_pkg::PerW-1:0] in_period_us,
  input  wire logic                   in_abort,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic signed [ANGLE_WIDTH-1:0] out_joint_cmd_0,
  output logic signed [ANGLE_WIDTH-1:0] out_joint_cmd_1,
  output logic signed [ANGLE_WIDTH-1:0] out_joint_cmd_2,
  output logic signed [ANGLE_WIDTH-1:0] out_joint_cmd_3,
  output logic signed [ANGLE_WIDTH-1:0] out_joint_cmd_4,
  output logic signed [ANGLE_WIDTH-1:0] out_joint_cmd_5,
  output logic signed [ANGLE_WIDTH-1:0] out_joint_cmd_6,
  output logic signed [qjtg_pkg::TlW-1:0] out_time_left_us,
  output logic                        out_motion_done,
  output logic                        out_preempted
);
  import qjtg_pkg::*;

  logic [DurW-1:0] dur_r;
  logic            fj_valid, fj_ready, bj_valid, bj_ready, ld_en, busy;
  job_t            fj, bj;
  logic [OutJoints-1:0][ANGLE_WIDTH-1:0] cmd;

  // Duration register.
  always_ff @(posedge clk) begin
    if (!rst_n) dur_r <= DurReset;
    else if (cfg_we) dur_r <= cfg_wdata;
  end

  assign ld_en = in_valid && in_ready && (req_t'(in_req_type) == REQ_LOAD);

  // A tick is still queued or in work in the back end.
  assign busy = bj_valid || !bj_ready;

  qjtg_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_req_type, .in_period_us, .in_abort,
    .dur(dur_r), .busy, .job_valid(fj_valid), .job(fj), .job_ready(fj_ready)
  );

  qjtg_queue u_queue (
    .clk, .rst_n, .wr_valid(fj_valid), .wr_data(fj), .wr_ready(fj_ready),
    .rd_valid(bj_valid), .rd_data(bj), .rd_ready(bj_ready)
  );

  qjtg_back #(.NUM_JOINTS(NUM_JOINTS), .ANGLE_WIDTH(ANGLE_WIDTH)) u_back (
    .clk, .rst_n, .job_valid(bj_valid), .job(bj), .job_ready(bj_ready),
    .out_ready, .out_valid, .cmd, .tl(out_time_left_us),
    .done(out_motion_done), .pre(out_preempted),
    .ld_en, .ld_idx(in_joint_index), .ld_start(in_start_angle),
    .ld_goal(in_goal_angle)
  );

  assign out_joint_cmd_0 = cmd[0];
  assign out_joint_cmd_1 = cmd[1];
  assign out_joint_cmd_2 = cmd[2];
  assign out_joint_cmd_3 = cmd[3];
  assign out_joint_cmd_4 = cmd[4];
  assign out_joint_cmd_5 = cmd[5];
  assign out_joint_cmd_6 = cmd[6];

endmodule : quintic_joint_trajectory_gen_unit

`default_nettype wire
